@@ src/freshness_replay_window_table_defines.svh @@
// Assertion macros for the freshness replay window table.
// Included by modules that assert; no other dependencies.
`ifndef FRESHNESS_REPLAY_WINDOW_TABLE_DEFINES_SVH
`define FRESHNESS_REPLAY_WINDOW_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FRWT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FRWT_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRWT_ASSERT(label, clk, rst_n, prop, msg)
`define FRWT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ src/frwt_pkg.sv @@
// Shared types and constants for the freshness replay window table.
// No dependencies.
package frwt_pkg;
  localparam int unsigned Entries = 16;
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;

  typedef enum logic [2:0] {
    REQ_REGISTER = 3'd0, REQ_INCREMENT = 3'd1, REQ_VERIFY = 3'd2,
    REQ_SYNC = 3'd3, REQ_READ = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_UNKNOWN = 3'd1, ST_DUPLICATE = 3'd2, ST_FULL = 3'd3,
    ST_EXPIRED = 3'd4, ST_TOO_OLD = 3'd5, ST_TOO_NEW = 3'd6
  } status_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] pdu_id;
    logic [63:0] counter_in;
    logic [31:0] now_ms;
    logic [31:0] max_age_ms;
    logic [31:0] backward_tolerance;
    logic [31:0] forward_tolerance;
    logic [1:0]  sync_state_in;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] counter_out;
    logic [1:0]  sync_state_out;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch request
    logic lookup;   // register hit/entry data
    logic execute;  // update entry, form result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;
  } stat_t;
endpackage

@@ src/frwt_ctrl.sv @@
// Controller state machine for the freshness replay window table.
// Depends on frwt_pkg.
`include "freshness_replay_window_table_defines.svh"
module frwt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  frwt_pkg::stat_t stat_i,
  output logic            busy_o,
  output frwt_pkg::cmd_t  cmd_o
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_LOOK = 3'b010, S_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_i) state_d = S_LOOK;
      S_LOOK: state_d = S_EXEC;
      S_EXEC: if (stat_i.done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign cmd_o.capture = (state_q == S_IDLE) && start_i;
  assign cmd_o.lookup = (state_q == S_LOOK);
  assign cmd_o.execute = (state_q == S_EXEC);

  `FRWT_ASSERT(a_look_after_start, clk_i, rst_ni, cmd_o.capture |=> cmd_o.lookup, "no lookup")
  `FRWT_ASSERT(a_exec_after_look, clk_i, rst_ni, cmd_o.lookup |=> cmd_o.execute, "no exec")
  `FRWT_ASSERT(a_idle_after_exec, clk_i, rst_ni, cmd_o.execute |=> !busy_o, "stuck busy")
endmodule

@@ src/frwt_datapath.sv @@
// Entry table, tag match and window checks for the freshness table.
// Depends on frwt_pkg.
`include "freshness_replay_window_table_defines.svh"
module frwt_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  frwt_pkg::req_t  req_i,
  input  frwt_pkg::cmd_t  cmd_i,
  output frwt_pkg::stat_t stat_o,
  output logic            result_valid_o,
  output frwt_pkg::rsp_t  result_o
);
  localparam int unsigned N = frwt_pkg::Entries;
  localparam int unsigned W = frwt_pkg::IdxW;

  logic [N-1:0]  valid_q;
  logic [15:0]   tag_q   [N];
  logic [63:0]   cnt_q   [N];
  logic [63:0]   hi_q    [N];
  logic          seen_q  [N];
  logic [1:0]    sync_q  [N];
  logic [31:0]   last_q  [N];
  logic [95:0]   lim_q   [N];

  frwt_pkg::req_t req_q;

  // lookup stage registers
  logic         hit_q, free_any_q;
  logic [W-1:0] hit_idx_q, free_idx_q;
  logic [63:0]  e_cnt_q, e_hi_q;
  logic         e_seen_q;
  logic [1:0]   e_sync_q;
  logic [31:0]  e_elapsed_q;
  logic [95:0]  e_lim_q;

  logic         hit, free_any;
  logic [W-1:0] hit_idx, free_idx;

  always_comb begin
    hit = 1'b0; hit_idx = '0; free_any = 1'b0; free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (valid_q[i] && tag_q[i] == req_q.pdu_id) begin
        hit = 1'b1; hit_idx = W'(i);
      end
      if (!valid_q[i]) begin
        free_any = 1'b1; free_idx = W'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
    if (cmd_i.lookup) begin
      hit_q <= hit; hit_idx_q <= hit_idx;
      free_any_q <= free_any; free_idx_q <= free_idx;
      e_cnt_q <= cnt_q[hit_idx]; e_hi_q <= hi_q[hit_idx];
      e_seen_q <= seen_q[hit_idx]; e_sync_q <= sync_q[hit_idx];
      e_elapsed_q <= req_q.now_ms - last_q[hit_idx];
      e_lim_q <= lim_q[hit_idx];
    end
  end

  // verify decision
  logic [31:0] age_lim, btol, ftol;
  logic        rx_gt, rx_le;
  logic [63:0] back, fwd, cnt_inc;
  frwt_pkg::status_e vstat;

  assign age_lim = e_lim_q[95:64];
  assign btol = e_lim_q[63:32];
  assign ftol = e_lim_q[31:0];
  assign rx_gt = req_q.counter_in > e_hi_q;
  assign rx_le = !rx_gt;
  assign back = e_hi_q - req_q.counter_in;
  assign fwd = req_q.counter_in - e_hi_q;
  assign cnt_inc = e_cnt_q + 64'd1;

  always_comb begin
    vstat = frwt_pkg::ST_OK;
    if (age_lim != 32'd0 && e_elapsed_q > age_lim) vstat = frwt_pkg::ST_EXPIRED;
    else if (e_seen_q && rx_le && (back == 64'd0 || back > {32'd0, btol}))
      vstat = frwt_pkg::ST_TOO_OLD;
    else if (rx_gt && fwd > {32'd0, ftol}) vstat = frwt_pkg::ST_TOO_NEW;
  end

  frwt_pkg::rsp_t rsp_d;
  logic           wr_reg, wr_inc, wr_ver, wr_sync;

  always_comb begin
    rsp_d = '0;
    wr_reg = 1'b0; wr_inc = 1'b0; wr_ver = 1'b0; wr_sync = 1'b0;
    case (req_q.req_type)
      frwt_pkg::REQ_REGISTER: begin
        if (hit_q) rsp_d.status = frwt_pkg::ST_DUPLICATE;
        else if (!free_any_q) rsp_d.status = frwt_pkg::ST_FULL;
        else wr_reg = 1'b1;
      end
      frwt_pkg::REQ_INCREMENT: begin
        if (!hit_q) rsp_d.status = frwt_pkg::ST_UNKNOWN;
        else begin
          wr_inc = 1'b1; rsp_d.counter_out = cnt_inc;
        end
      end
      frwt_pkg::REQ_VERIFY: begin
        if (!hit_q) rsp_d.status = frwt_pkg::ST_UNKNOWN;
        else begin
          rsp_d.status = vstat;
          wr_ver = (vstat == frwt_pkg::ST_OK);
        end
      end
      frwt_pkg::REQ_SYNC: begin
        if (!hit_q) rsp_d.status = frwt_pkg::ST_UNKNOWN;
        else wr_sync = 1'b1;
      end
      frwt_pkg::REQ_READ: begin
        if (!hit_q) rsp_d.status = frwt_pkg::ST_UNKNOWN;
        else begin
          rsp_d.counter_out = e_cnt_q; rsp_d.sync_state_out = e_sync_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      if (wr_reg) begin
        tag_q[free_idx_q] <= req_q.pdu_id;
        cnt_q[free_idx_q] <= '0;
        hi_q[free_idx_q] <= '0;
        seen_q[free_idx_q] <= 1'b0;
        sync_q[free_idx_q] <= '0;
        last_q[free_idx_q] <= req_q.now_ms;
        lim_q[free_idx_q] <= {req_q.max_age_ms, req_q.backward_tolerance,
                              req_q.forward_tolerance};
      end
      if (wr_inc) cnt_q[hit_idx_q] <= cnt_inc;
      if (wr_ver) begin
        seen_q[hit_idx_q] <= 1'b1;
        if (rx_gt) hi_q[hit_idx_q] <= req_q.counter_in;
      end
      if (wr_sync) begin
        hi_q[hit_idx_q] <= req_q.counter_in;
        sync_q[hit_idx_q] <= req_q.sync_state_in;
        last_q[hit_idx_q] <= req_q.now_ms;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.execute;
      if (cmd_i.execute && wr_reg) valid_q[free_idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) result_o <= rsp_d;
  end

  assign stat_o.done = cmd_i.execute;

  `FRWT_ASSERT(a_reg_free, clk_i, rst_ni, cmd_i.execute && wr_reg |-> !valid_q[free_idx_q], "reg into used entry")
  `FRWT_ASSERT(a_reg_grows, clk_i, rst_ni, cmd_i.execute && wr_reg |=> $countones(valid_q) == $past($countones(valid_q)) + 1, "valid count")
  `FRWT_ASSERT(a_hit_valid, clk_i, rst_ni, cmd_i.execute && hit_q |-> valid_q[hit_idx_q], "hit on invalid entry")
endmodule

@@ src/freshness_replay_window_table.sv @@
// Top level of the freshness replay window table.
// Depends on frwt_pkg, frwt_ctrl and frwt_datapath.
//
// channel   ports                       transfer when
// request   start_i, busy_o, req_i      start_i && !busy_o at clk_i rise
// result    result_valid_o, result_o    result_valid_o high (one cycle)
//
// Each request passes through capture, lookup of the 16-entry tag
// match (registered), then execute with window checks and entry update.
// The result strobe rises in the cycle after execute; busy_o drops then,
// so a new request is taken only once the last one is through.
// Reset clears the entry valid bits and the controller; no clearing pass.
// The result channel has no stall; results are one-cycle strobes.
module freshness_replay_window_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  frwt_pkg::req_t  req_i,
  output logic            busy_o,
  output logic            result_valid_o,
  output frwt_pkg::rsp_t  result_o
);
  frwt_pkg::cmd_t  cmd;
  frwt_pkg::stat_t stat;

  frwt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .busy_o (busy_o),
    .cmd_o  (cmd)
  );

  frwt_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );
endmodule

@@ bench/freshness_replay_window_table_tb.sv @@
// Self-checking bench for the freshness replay window table: directed table then random traffic.
// Depends on frwt_pkg and the freshness_replay_window_table RTL.
// Results are compared against an in-bench model of the entry table.
module freshness_replay_window_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumEntries = 16;
  localparam int WatchLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  frwt_pkg::req_t req_i = '0;
  logic busy_o;
  logic result_valid_o;
  frwt_pkg::rsp_t result_o;

  freshness_replay_window_table u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .result_valid_o(result_valid_o), .result_o(result_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the entry table
  logic        sh_valid [NumEntries];
  logic [15:0] sh_tag   [NumEntries];
  logic [63:0] sh_local [NumEntries];
  logic [63:0] sh_high  [NumEntries];
  logic        sh_seen  [NumEntries];
  logic [1:0]  sh_sync  [NumEntries];
  logic [31:0] sh_lsync [NumEntries];
  logic [31:0] sh_age   [NumEntries];
  logic [31:0] sh_btol  [NumEntries];
  logic [31:0] sh_ftol  [NumEntries];

  frwt_pkg::rsp_t pending_rsp[$];
  int   err_cnt = 0;
  int   idle_cycles = 0;

  // Small pool of PDU tags so requests hit registered entries often
  logic [15:0] tag_pool [24];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  function automatic int lookup_tag(input logic [15:0] tag);
    for (int i = 0; i < NumEntries; i++)
      if (sh_valid[i] && sh_tag[i] == tag) return i;
    return -1;
  endfunction

  // Freshness checks for one verify on entry e
  function automatic frwt_pkg::status_e check_freshness(input int e, input logic [63:0] rx,
                                                        input logic [31:0] now);
    logic [63:0] hi;
    logic [31:0] elapsed;
    hi = sh_high[e];
    elapsed = now - sh_lsync[e];
    if (sh_age[e] != 0 && elapsed > sh_age[e]) return frwt_pkg::ST_EXPIRED;
    if (sh_seen[e] && rx <= hi) begin
      if (hi == rx || (hi - rx) > {32'd0, sh_btol[e]}) return frwt_pkg::ST_TOO_OLD;
    end
    if (rx > hi && (rx - hi) > {32'd0, sh_ftol[e]}) return frwt_pkg::ST_TOO_NEW;
    sh_seen[e] = 1'b1;
    if (rx > hi) sh_high[e] = rx;
    return frwt_pkg::ST_OK;
  endfunction

  function automatic frwt_pkg::rsp_t apply_request(input frwt_pkg::req_t r);
    frwt_pkg::rsp_t o;
    int e;
    int f;
    o = '0;
    o.status = frwt_pkg::ST_OK;
    e = lookup_tag(r.pdu_id);
    case (r.req_type)
      frwt_pkg::REQ_REGISTER: begin
        if (e >= 0) begin
          o.status = frwt_pkg::ST_DUPLICATE;
        end else begin
          f = -1;
          for (int i = NumEntries - 1; i >= 0; i--) if (!sh_valid[i]) f = i;
          if (f < 0) begin
            o.status = frwt_pkg::ST_FULL;
          end else begin
            sh_valid[f] = 1'b1; sh_tag[f] = r.pdu_id; sh_local[f] = '0;
            sh_high[f] = '0; sh_seen[f] = 1'b0; sh_sync[f] = '0;
            sh_lsync[f] = r.now_ms; sh_age[f] = r.max_age_ms;
            sh_btol[f] = r.backward_tolerance; sh_ftol[f] = r.forward_tolerance;
          end
        end
      end
      frwt_pkg::REQ_INCREMENT: begin
        if (e < 0) begin
          o.status = frwt_pkg::ST_UNKNOWN;
        end else begin
          sh_local[e] = sh_local[e] + 64'd1;
          o.counter_out = sh_local[e];
        end
      end
      frwt_pkg::REQ_VERIFY: begin
        if (e < 0) o.status = frwt_pkg::ST_UNKNOWN;
        else o.status = check_freshness(e, r.counter_in, r.now_ms);
      end
      frwt_pkg::REQ_SYNC: begin
        if (e < 0) begin
          o.status = frwt_pkg::ST_UNKNOWN;
        end else begin
          sh_high[e] = r.counter_in; sh_sync[e] = r.sync_state_in;
          sh_lsync[e] = r.now_ms;
        end
      end
      frwt_pkg::REQ_READ: begin
        if (e < 0) begin
          o.status = frwt_pkg::ST_UNKNOWN;
        end else begin
          o.counter_out = sh_local[e];
          o.sync_state_out = sh_sync[e];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Issue one request after a random gap, waiting for the handshake.
  // start_i stays high across a zero gap; the caller drops it at the end.
  task automatic send_request(input frwt_pkg::req_t r, input bit has_fixed,
                              input frwt_pkg::rsp_t fixed);
    frwt_pkg::rsp_t want;
    int gap;
    gap = $urandom_range(0, 17);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
    want = apply_request(r);
    if (has_fixed) begin
      if (want.status != fixed.status)
        report_mismatch("table status vs model", 64'(want.status), 64'(fixed.status));
      if (want.counter_out != fixed.counter_out)
        report_mismatch("table counter vs model", want.counter_out, fixed.counter_out);
      if (want.sync_state_out != fixed.sync_state_out)
        report_mismatch("table sync vs model", 64'(want.sync_state_out),
                        64'(fixed.sync_state_out));
    end
    pending_rsp.push_back(want);
  endtask

  // Result monitor: results cannot be stalled, check each strobe on arrival.
  always @(posedge clk_i) begin
    frwt_pkg::rsp_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected result", result_o.counter_out, 64'd0);
      end else begin
        want = pending_rsp.pop_front();
        if (result_o.status !== want.status)
          report_mismatch("status", 64'(result_o.status), 64'(want.status));
        if (result_o.counter_out !== want.counter_out)
          report_mismatch("counter_out", result_o.counter_out, want.counter_out);
        if (result_o.sync_state_out !== want.sync_state_out)
          report_mismatch("sync_state_out", 64'(result_o.sync_state_out),
                          64'(want.sync_state_out));
      end
    end
  end

  // Watchdog: cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic frwt_pkg::req_t make_req(input frwt_pkg::req_e op,
                                              input logic [15:0] tag,
                                              input logic [63:0] cnt, input logic [31:0] now,
                                              input logic [31:0] age, input logic [31:0] bt,
                                              input logic [31:0] ft, input logic [1:0] ss);
    frwt_pkg::req_t r;
    r.req_type = op; r.pdu_id = tag; r.counter_in = cnt; r.now_ms = now;
    r.max_age_ms = age; r.backward_tolerance = bt; r.forward_tolerance = ft;
    r.sync_state_in = ss;
    return r;
  endfunction

  typedef struct {
    frwt_pkg::req_t r;
    bit             fixed;
    frwt_pkg::rsp_t rsp;
  } stim_row_t;

  function automatic frwt_pkg::rsp_t rsp_of(input frwt_pkg::status_e s,
                                            input logic [63:0] c,
                                            input logic [1:0] ss);
    frwt_pkg::rsp_t o;
    o.status = s; o.counter_out = c; o.sync_state_out = ss;
    return o;
  endfunction

  stim_row_t dir_rows[$];
  logic [31:0] clock_ms = 0;

  initial begin
    frwt_pkg::req_t r;
    int k;
    int op_pick;
    for (int i = 0; i < NumEntries; i++) sh_valid[i] = 1'b0;
    for (int i = 0; i < 24; i++) tag_pool[i] = $urandom_range(0, 65535);
    tag_pool[0] = 16'h0000;
    tag_pool[1] = 16'hFFFF;

    // Directed table; rsp filled only where the answer is obvious
    dir_rows.push_back('{make_req(frwt_pkg::REQ_READ, 16'h1234, '1, '1, 0, 0, 0, 2'd3), 1,
                         rsp_of(frwt_pkg::ST_UNKNOWN, 0, 0)});
    dir_rows.push_back('{make_req(frwt_pkg::REQ_INCREMENT, 16'h0000, 0, 0, 0, 0, 0, 0), 1,
                         rsp_of(frwt_pkg::ST_UNKNOWN, 0, 0)});
    dir_rows.push_back('{make_req(frwt_pkg::REQ_VERIFY, 16'hFFFF, 5, 0, 0, 0, 0, 0), 1,
                         rsp_of(frwt_pkg::ST_UNKNOWN, 0, 0)});
    dir_rows.push_back('{make_req(frwt_pkg::REQ_SYNC, 16'hFFFF, 5, 0, 0, 0, 0, 2'd1), 1,
                         rsp_of(frwt_pkg::ST_UNKNOWN, 0, 0)});
    dir_rows.push_back('{make_req(frwt_pkg::req_e'(3'd7), 16'hFFFF, '1, '1, '1, '1, '1,
                                  2'd3), 1,
                         rsp_of(frwt_pkg::ST_OK, 0, 0)});
    // register with age limit 10 at t=100, backward window 3, forward window 5
    dir_rows.push_back('{make_req(frwt_pkg::REQ_REGISTER, 16'hFFFF, 0, 100, 10, 3, 5, 0), 1,
                         rsp_of(frwt_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{make_req(frwt_pkg::REQ_REGISTER, 16'hFFFF, 0, 0, 0, 0, 0, 0), 1,
                         rsp_of(frwt_pkg::ST_DUPLICATE, 0, 0)});
    dir_rows.push_back('{make_req(frwt_pkg::REQ_VERIFY, 16'hFFFF, 6, 105, 0, 0, 0, 0), 1,
                         rsp_of(frwt_pkg::ST_TOO_NEW, 0, 0)});
    dir_rows.push_back('{make_req(frwt_pkg::REQ_VERIFY, 16'hFFFF, 5, 105, 0, 0, 0, 0), 1,
                         rsp_of(frwt_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{make_req(frwt_pkg::REQ_VERIFY, 16'hFFFF, 5, 105, 0, 0, 0, 0), 1,
                         rsp_of(frwt_pkg::ST_TOO_OLD, 0, 0)});
    dir_rows.push_back('{make_req(frwt_pkg::REQ_VERIFY, 16'hFFFF, 2, 105, 0, 0, 0, 0), 1,
                         rsp_of(frwt_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{make_req(frwt_pkg::REQ_VERIFY, 16'hFFFF, 1, 105, 0, 0, 0, 0), 1,
                         rsp_of(frwt_pkg::ST_TOO_OLD, 0, 0)});
    dir_rows.push_back('{make_req(frwt_pkg::REQ_VERIFY, 16'hFFFF, 7, 111, 0, 0, 0, 0), 1,
                         rsp_of(frwt_pkg::ST_EXPIRED, 0, 0)});
    dir_rows.push_back('{make_req(frwt_pkg::REQ_SYNC, 16'hFFFF, '1, 200, 0, 0, 0, 2'd3), 1,
                         rsp_of(frwt_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{make_req(frwt_pkg::REQ_READ, 16'hFFFF, 0, 200, 0, 0, 0, 0), 1,
                         rsp_of(frwt_pkg::ST_OK, 0, 2'd3)});
    dir_rows.push_back('{make_req(frwt_pkg::REQ_VERIFY, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFC,
                                  210, 0, 0, 0, 0), 0, '0});
    // zero tag with all-ones limits: age never expires, time wraps
    dir_rows.push_back('{make_req(frwt_pkg::REQ_REGISTER, 16'h0000, 0, '1, '1, '1, '1,
                                  2'd3), 1,
                         rsp_of(frwt_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{make_req(frwt_pkg::REQ_VERIFY, 16'h0000, 64'h0000_0000_FFFF_FFFF,
                                  32'd5, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{make_req(frwt_pkg::REQ_INCREMENT, 16'h0000, 0, 0, 0, 0, 0, 0), 1,
                         rsp_of(frwt_pkg::ST_OK, 1, 0)});
    // fill the table, then one more register is refused
    for (int i = 0; i < NumEntries - 2; i++)
      dir_rows.push_back('{make_req(frwt_pkg::REQ_REGISTER, 16'h0100 + i[15:0], 0, 0, 0, 0,
                                    0, 0), 1,
                           rsp_of(frwt_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{make_req(frwt_pkg::REQ_REGISTER, 16'h0555, 0, 0, 0, 0, 0, 0), 1,
                         rsp_of(frwt_pkg::ST_FULL, 0, 0)});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_request(dir_rows[i].r, dir_rows[i].fixed, dir_rows[i].rsp);
    start_i <= 1'b0;

    // Hold off until the table has drained
    wait (pending_rsp.size() == 0);

    // Random part. Table is full of directed entries: pool tags other than
    // 0000 and FFFF miss; walking counters give window hits.
    for (k = 0; k < 1250; k++) begin
      r = '0;
      op_pick = $urandom_range(0, 99);
      r.pdu_id = ($urandom_range(0, 9) == 0) ? 16'($urandom()) :
                 (($urandom_range(0, 1) == 0) ? tag_pool[$urandom_range(0, 23)]
                                              : 16'h0100 + 16'($urandom_range(0, 13)));
      clock_ms = clock_ms + $urandom_range(0, 40);
      r.now_ms = ($urandom_range(0, 19) == 0) ? 32'($urandom()) : clock_ms;
      r.max_age_ms = ($urandom_range(0, 3) == 0) ? 0 :
                     (($urandom_range(0, 9) == 0) ? 32'($urandom())
                                                  : 32'($urandom_range(1, 500)));
      r.backward_tolerance = ($urandom_range(0, 9) == 0) ? 32'($urandom())
                                                         : 32'($urandom_range(0, 8));
      r.forward_tolerance = ($urandom_range(0, 9) == 0) ? 32'($urandom())
                                                        : 32'($urandom_range(0, 8));
      r.sync_state_in = 2'($urandom_range(0, 3));
      if (op_pick < 5) r.req_type = 3'($urandom_range(5, 7));
      else if (op_pick < 20) r.req_type = frwt_pkg::REQ_REGISTER;
      else if (op_pick < 35) r.req_type = frwt_pkg::REQ_INCREMENT;
      else if (op_pick < 75) r.req_type = frwt_pkg::REQ_VERIFY;
      else if (op_pick < 85) r.req_type = frwt_pkg::REQ_SYNC;
      else r.req_type = frwt_pkg::REQ_READ;
      if (lookup_tag(r.pdu_id) >= 0 && $urandom_range(0, 3) != 0)
        r.counter_in = sh_high[lookup_tag(r.pdu_id)] + 64'($urandom_range(0, 12)) - 64'd6;
      else
        r.counter_in = {32'($urandom()), 32'($urandom())};
      send_request(r, 0, '0);
    end
    start_i <= 1'b0;

    wait (pending_rsp.size() == 0);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
